// ===== rtl/sale_pkg.sv =====
package sale_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] ACT_INSERT     = 3'd0;
  localparam logic [2:0] ACT_SEARCH     = 3'd1;
  localparam logic [2:0] ACT_REMOVE_VAL = 3'd2;
  localparam logic [2:0] ACT_REMOVE_POS = 3'd3;
  localparam logic [2:0] ACT_DEDUPE     = 3'd4;

  localparam logic [1:0] ORD_APPEND = 2'd0;
  localparam logic [1:0] ORD_ASC    = 2'd1;
  localparam logic [1:0] ORD_DESC   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_SHF_RD,
    S_SHF_WR,
    S_INS_WR,
    S_SRC_RD,
    S_SRC_EV,
    S_RMV_RD,
    S_RMV_EV,
    S_RMP_RD,
    S_RMP_WR,
    S_DDP_RD,
    S_DDP_HOLD,
    S_DDP_KRD,
    S_DDP_KEV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]       action;
    logic signed [7:0] value;
    logic [1:0]       insert_order;
    logic [4:0]       position;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] found_index;
    logic [5:0] entry_count;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
  } cmp_t;

endpackage

// ===== rtl/sale_mem.sv =====
module sale_mem
  import sale_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   mem_req,
  output logic [7:0] rdata
);

  logic [7:0] mem [CAPACITY];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata_r <= mem[mem_req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sale_cmp.sv =====
module sale_cmp
  import sale_pkg::*;
(
  input  logic signed [7:0] a,
  input  logic signed [7:0] b,
  output cmp_t              cmp
);

  always_comb begin
    cmp.eq = (a == b);
    cmp.gt = (a > b);
    cmp.lt = (a < b);
  end

endmodule

// ===== rtl/sale_ctrl.sv =====
module sale_ctrl
  import sale_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  req_t              req,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output mem_req_t          mem_req,
  input  logic [7:0]        rdata,
  output logic signed [7:0] key,
  input  cmp_t              cmp
);

  state_t            state_r, state_nxt;
  logic signed [7:0] v_r, v_nxt;
  logic [1:0]        order_r, order_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              hit_r, hit_nxt;
  logic              ok_r, ok_nxt;
  logic [4:0]        idx_r, idx_nxt;

  logic [CNT_W-1:0] ip1, im1, ip2, wp1, kp1;
  logic             ins_adv;

  assign ip1 = i_r + CNT_W'(1);
  assign ip2 = i_r + CNT_W'(2);
  assign im1 = i_r - CNT_W'(1);
  assign wp1 = w_r + CNT_W'(1);
  assign kp1 = k_r + CNT_W'(1);

  assign ins_adv = (order_r == ORD_ASC) ? cmp.gt : cmp.lt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    v_r     <= v_nxt;
    order_r <= order_nxt;
    i_r     <= i_nxt;
    w_r     <= w_nxt;
    p_r     <= p_nxt;
    k_r     <= k_nxt;
    hit_r   <= hit_nxt;
    ok_r    <= ok_nxt;
    idx_r   <= idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    order_nxt     = order_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    ok_nxt        = ok_r;
    idx_nxt       = idx_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = i_r[IDX_W-1:0];
    mem_req.wdata = rdata;
    mem_req.raddr = i_r[IDX_W-1:0];
    req_ready     = (state_r == S_IDLE);
    res_valid     = (state_r == S_DONE);

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          v_nxt     = req.value;
          order_nxt = req.insert_order;
          ok_nxt    = 1'b0;
          idx_nxt   = '0;
          i_nxt     = '0;
          w_nxt     = '0;
          hit_nxt   = 1'b0;
          unique case (req.action)
            ACT_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                state_nxt = S_DONE;
              end else if ((req.insert_order == ORD_ASC || req.insert_order == ORD_DESC)
                           && count_r != '0) begin
                state_nxt = S_INS_RD;
              end else begin
                p_nxt     = count_r;
                state_nxt = S_INS_WR;
              end
            end
            ACT_SEARCH: begin
              state_nxt = (count_r == '0) ? S_DONE : S_SRC_RD;
            end
            ACT_REMOVE_VAL: begin
              state_nxt = (count_r == '0) ? S_DONE : S_RMV_RD;
            end
            ACT_REMOVE_POS: begin
              i_nxt = CNT_W'(req.position);
              if (CNT_W'(req.position) >= count_r) begin
                state_nxt = S_DONE;
              end else if (CNT_W'(req.position) + CNT_W'(1) == count_r) begin
                count_nxt = count_r - CNT_W'(1);
                ok_nxt    = 1'b1;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RMP_RD;
              end
            end
            ACT_DEDUPE: begin
              ok_nxt    = 1'b1;
              state_nxt = (count_r == '0) ? S_DONE : S_DDP_RD;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_EV;
      end
      S_INS_EV: begin
        if (ins_adv) begin
          i_nxt = ip1;
          if (ip1 == count_r) begin
            p_nxt     = count_r;
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_INS_RD;
          end
        end else begin
          p_nxt     = i_r;
          i_nxt     = count_r;
          state_nxt = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        mem_req.raddr = im1[IDX_W-1:0];
        state_nxt     = S_SHF_WR;
      end
      S_SHF_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r[IDX_W-1:0];
        i_nxt         = im1;
        state_nxt     = (im1 == p_r) ? S_INS_WR : S_SHF_RD;
      end
      S_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = p_r[IDX_W-1:0];
        mem_req.wdata = v_r;
        count_nxt     = count_r + CNT_W'(1);
        ok_nxt        = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SRC_RD: begin
        state_nxt = S_SRC_EV;
      end
      S_SRC_EV: begin
        if (cmp.eq) begin
          ok_nxt    = 1'b1;
          idx_nxt   = i_r[4:0];
          state_nxt = S_DONE;
        end else begin
          i_nxt     = ip1;
          state_nxt = (ip1 == count_r) ? S_DONE : S_SRC_RD;
        end
      end
      S_RMV_RD: begin
        state_nxt = S_RMV_EV;
      end
      S_RMV_EV: begin
        i_nxt = ip1;
        if (cmp.eq) begin
          hit_nxt = 1'b1;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = w_r[IDX_W-1:0];
          w_nxt         = wp1;
        end
        if (ip1 == count_r) begin
          count_nxt = w_nxt;
          ok_nxt    = hit_nxt;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RMV_RD;
        end
      end
      S_RMP_RD: begin
        mem_req.raddr = ip1[IDX_W-1:0];
        state_nxt     = S_RMP_WR;
      end
      S_RMP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r[IDX_W-1:0];
        i_nxt         = ip1;
        if (ip2 == count_r) begin
          count_nxt = count_r - CNT_W'(1);
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RMP_RD;
        end
      end
      S_DDP_RD: begin
        state_nxt = S_DDP_HOLD;
      end
      S_DDP_HOLD: begin
        v_nxt = rdata;
        k_nxt = '0;
        if (w_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = w_r[IDX_W-1:0];
          w_nxt         = wp1;
          i_nxt         = ip1;
          if (ip1 == count_r) begin
            count_nxt = wp1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DDP_RD;
          end
        end else begin
          state_nxt = S_DDP_KRD;
        end
      end
      S_DDP_KRD: begin
        mem_req.raddr = k_r[IDX_W-1:0];
        state_nxt     = S_DDP_KEV;
      end
      S_DDP_KEV: begin
        if (cmp.eq || kp1 == w_r) begin
          if (!cmp.eq) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = w_r[IDX_W-1:0];
            mem_req.wdata = v_r;
            w_nxt         = wp1;
          end
          i_nxt = ip1;
          if (ip1 == count_r) begin
            count_nxt = w_nxt;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DDP_RD;
          end
        end else begin
          k_nxt     = kp1;
          state_nxt = S_DDP_KRD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign key             = v_r;
  assign res.ok          = ok_r;
  assign res.found_index = idx_r;
  assign res.entry_count = count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("memory written outside an operation");

  a_ready_vs_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_ready |-> !res_valid)
    else $error("request taken while a result is pending");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> req_ready)
    else $error("sequencer did not return to idle after delivery");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list by one");
`endif

endmodule

// ===== rtl/static_array_list_engine.sv =====
// An append insert goes from acceptance to its write state, then to the result.
// A scan step through the registered entry memory takes a read state and an evaluate
// state per entry; a search or remove-by-value scans the list, a sorted insert scans
// and then shifts, and a dedupe compares each entry with the kept ones up to a match.
// One item is in work at a time; the next one is taken once the sequencer is back in
// idle after the result is taken. Reset (rst_n low, synchronous) empties the list.
module static_array_list_engine
  import sale_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: action[2:0], value[10:3], insert_order[12:11],
  // position[17:13], zero fill.
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: ok[0], found_index[5:1], entry_count[11:6], zero fill.
  output logic [15:0] out_tdata
);

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  mem_req_t          mem_req;
  logic [7:0]        rdata;
  logic signed [7:0] key;
  cmp_t              cmp;
  logic              out_valid_r;
  res_t              out_res_r;

  assign req.action       = in_tdata[2:0];
  assign req.value        = in_tdata[10:3];
  assign req.insert_order = in_tdata[12:11];
  assign req.position     = in_tdata[17:13];

  sale_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  sale_cmp u_cmp (
    .a   (key),
    .b   (rdata),
    .cmp (cmp)
  );

  sale_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .key       (key),
    .cmp       (cmp)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_res_r.entry_count, out_res_r.found_index, out_res_r.ok};

endmodule

// ===== dv/tb_static_array_list_engine.sv =====
module tb_static_array_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import sale_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [2:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;
  localparam logic [1:0] ORD_UNUSED     = 2'd3;

  localparam int DIR_N      = 24;
  localparam int N_RANDOM   = 830;
  localparam int QUIET_TAIL = 100;
  localparam int DRAIN_AT   = 300;
  localparam int PHASE_LEN  = 70;
  localparam int SETTLE_CYC = 1100;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} mix_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  logic signed [7:0] list_mem [CAPACITY];
  int   list_len;
  res_t pending_results [$];
  bit   idle_on = 1'b1;
  int   n_sent, n_checked, n_errors, full_refused, search_hits, peak_len;
  dir_row_t dir_tab [DIR_N];

  static_array_list_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic res_t list_apply(req_t rq);
    res_t res;
    logic signed [7:0] v;
    int p, i, w, k;
    bit hit, seen;
    res = '0;
    v = rq.value;
    case (rq.action)
      ACT_INSERT: begin
        if (list_len < CAPACITY) begin
          p = list_len;
          if (rq.insert_order == ORD_ASC || rq.insert_order == ORD_DESC) begin
            p = 0;
            while (p < list_len && ((rq.insert_order == ORD_ASC) ? (v > list_mem[p])
                                                                 : (v < list_mem[p])))
              p++;
            for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          end
          list_mem[p] = v;
          list_len++;
          res.ok = 1'b1;
        end else begin
          full_refused++;
        end
      end
      ACT_SEARCH: begin
        for (i = 0; i < list_len && !res.ok; i++) begin
          if (list_mem[i] == v) begin
            res.ok = 1'b1;
            res.found_index = 5'(i);
          end
        end
        if (res.ok) search_hits++;
      end
      ACT_REMOVE_VAL: begin
        w = 0;
        hit = 1'b0;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == v) hit = 1'b1;
          else begin
            list_mem[w] = list_mem[i];
            w++;
          end
        end
        list_len = w;
        res.ok = hit;
      end
      ACT_REMOVE_POS: begin
        if (int'(rq.position) < list_len) begin
          for (i = rq.position; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          res.ok = 1'b1;
        end
      end
      ACT_DEDUPE: begin
        w = 0;
        for (i = 0; i < list_len; i++) begin
          seen = 1'b0;
          for (k = 0; k < w; k++)
            if (list_mem[k] == list_mem[i]) seen = 1'b1;
          if (!seen) begin
            list_mem[w] = list_mem[i];
            w++;
          end
        end
        list_len = w;
        res.ok = 1'b1;
      end
      default: res.ok = 1'b0;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    res.entry_count = 6'(list_len);
    return res;
  endfunction

  function automatic dir_row_t dir_row(logic [2:0] act, int val, logic [1:0] ord, int pos,
                                       bit typed, bit ok, int idx, int cnt);
    dir_row_t r;
    r.req.action       = act;
    r.req.value        = 8'(val);
    r.req.insert_order = ord;
    r.req.position     = 5'(pos);
    r.typed            = typed;
    r.res.ok           = ok;
    r.res.found_index  = 5'(idx);
    r.res.entry_count  = 6'(cnt);
    return r;
  endfunction

  function automatic logic signed [7:0] pick_value();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 8) - 4);
  endfunction

  function automatic req_t gen_request(mix_t mode);
    req_t rq;
    int roll;
    int cut [5];
    rq.value = pick_value();
    if (list_len > 0 && $urandom_range(0, 2) == 0)
      rq.value = list_mem[$urandom_range(0, list_len - 1)];
    rq.insert_order = 2'($urandom_range(0, 3));
    if (list_len > 0 && $urandom_range(0, 3) != 0)
      rq.position = 5'($urandom_range(0, list_len - 1));
    else
      rq.position = 5'($urandom_range(0, 31));
    case (mode)
      MIX_FILL:  cut = '{75, 85, 90, 95, 97};
      MIX_DRAIN: cut = '{15, 30, 60, 88, 96};
      default:   cut = '{40, 60, 72, 85, 95};
    endcase
    roll = $urandom_range(0, 99);
    if (roll < cut[0])      rq.action = ACT_INSERT;
    else if (roll < cut[1]) rq.action = ACT_SEARCH;
    else if (roll < cut[2]) rq.action = ACT_REMOVE_VAL;
    else if (roll < cut[3]) rq.action = ACT_REMOVE_POS;
    else if (roll < cut[4]) rq.action = ACT_DEDUPE;
    else                    rq.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    return rq;
  endfunction

  function automatic int pick_gap();
    if (idle_on && $urandom_range(0, 99) < 25) return $urandom_range(1, 11);
    return 0;
  endfunction

  task automatic send_request(input req_t rq, input bit typed, input res_t typed_res,
                              input int gap);
    res_t want;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, rq.position, rq.insert_order, rq.value, rq.action};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = list_apply(rq);
    pending_results.push_back(typed ? typed_res : want);
    n_sent++;
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    int k;
    mix_t mode;
    mode = MIX_FILL;
    dir_tab = '{
      dir_row(ACT_SEARCH,     0,    ORD_APPEND, 0,  1, 0, 0, 0),
      dir_row(ACT_REMOVE_POS, 0,    ORD_APPEND, 0,  1, 0, 0, 0),
      dir_row(ACT_REMOVE_VAL, -128, ORD_APPEND, 0,  1, 0, 0, 0),
      dir_row(ACT_DEDUPE,     0,    ORD_APPEND, 0,  1, 1, 0, 0),
      dir_row(ACT_UNUSED_LO,  0,    ORD_APPEND, 0,  1, 0, 0, 0),
      dir_row(ACT_UNUSED_MID, 127,  ORD_UNUSED, 31, 1, 0, 0, 0),
      dir_row(ACT_UNUSED_HI,  -1,   ORD_DESC,   31, 1, 0, 0, 0),
      dir_row(ACT_INSERT,     127,  ORD_APPEND, 0,  1, 1, 0, 1),
      dir_row(ACT_INSERT,     -128, ORD_APPEND, 31, 1, 1, 0, 2),
      dir_row(ACT_INSERT,     0,    ORD_UNUSED, 0,  0, 0, 0, 0),
      dir_row(ACT_INSERT,     5,    ORD_ASC,    0,  0, 0, 0, 0),
      dir_row(ACT_INSERT,     -1,   ORD_DESC,   0,  0, 0, 0, 0),
      dir_row(ACT_INSERT,     5,    ORD_ASC,    0,  0, 0, 0, 0),
      dir_row(ACT_SEARCH,     127,  ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_SEARCH,     42,   ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_INSERT,     -128, ORD_DESC,   0,  0, 0, 0, 0),
      dir_row(ACT_DEDUPE,     0,    ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_REMOVE_VAL, 5,    ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_REMOVE_POS, 0,    ORD_APPEND, 31, 0, 0, 0, 0),
      dir_row(ACT_REMOVE_POS, 0,    ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_INSERT,     127,  ORD_ASC,    0,  0, 0, 0, 0),
      dir_row(ACT_SEARCH,     -128, ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_REMOVE_VAL, 99,   ORD_APPEND, 0,  0, 0, 0, 0),
      dir_row(ACT_REMOVE_POS, 0,    ORD_APPEND, 2,  0, 0, 0, 0)
    };
    list_len = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_N; k++)
      send_request(dir_tab[k].req, dir_tab[k].typed, dir_tab[k].res, pick_gap());

    // Random part: phases that fill, drain or mix the list, so that the full
    // list and the empty list are both reached repeatedly.
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % PHASE_LEN == 0) begin
        mode    = mix_t'($urandom_range(0, 2));
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (k >= N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
      if (k == DRAIN_AT) wait_all_results();
      send_request(gen_request(mode), 1'b0, '0, pick_gap());
    end

    wait_all_results();
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Sent %0d items (%0d directed), checked %0d results.", n_sent, DIR_N, n_checked);
    $display("Inserts refused on a full list: %0d, search hits: %0d, longest list: %0d.",
             full_refused, search_hits, peak_len);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok          = out_tdata[0];
      got.found_index = out_tdata[5:1];
      got.entry_count = out_tdata[11:6];
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("Unexpected result: ok=%0d index=%0d count=%0d",
                   got.ok, got.found_index, got.entry_count);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.ok !== want.ok || got.found_index !== want.found_index ||
            got.entry_count !== want.entry_count) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Result %0d: expected ok=%0d idx=%0d cnt=%0d, got ok=%0d idx=%0d cnt=%0d",
                     n_checked, want.ok, want.found_index, want.entry_count,
                     got.ok, got.found_index, got.entry_count);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sale_pkg.sv
rtl/sale_mem.sv
rtl/sale_cmp.sv
rtl/sale_ctrl.sv
rtl/static_array_list_engine.sv
dv/tb_static_array_list_engine.sv
